// ----- rtl/core/fsac_pkg.sv -----
`default_nettype none

package fsac_pkg;

    // Frame size limit; the accumulator widths below follow from it.
    localparam int MAX_PIXELS = 65536;

    localparam int PIX_W = 16;
    localparam int CNT_W = $clog2(MAX_PIXELS + 1);
    localparam int SUM_W = PIX_W + CNT_W;
    localparam int SQ_W  = 2 * PIX_W + CNT_W;

    // n * sum_sq and sum * sum both fit in PROD_W bits.
    localparam int PROD_W = CNT_W + SQ_W;

    // Square root operand is (n * sum_sq - sum * sum) scaled by 2^16.
    localparam int VAR_FRAC_W = 16;
    localparam int X_W        = PROD_W + VAR_FRAC_W;
    localparam int RT_W       = X_W / 2;

    localparam int MEAN_FRAC_W = 8;
    localparam int MD_W        = SUM_W + MEAN_FRAC_W;
    localparam int DV_W        = (RT_W > MD_W) ? RT_W : MD_W;

    localparam int ALU_W0 = (PROD_W > RT_W + 3) ? PROD_W : RT_W + 3;
    localparam int ALU_W  = (ALU_W0 > DV_W) ? ALU_W0 : DV_W;
    localparam int STEP_W = $clog2(DV_W + 1);

    localparam int STAT_W  = 24;
    localparam int FACT_W  = 12;
    localparam int SPROD_W = STAT_W + FACT_W;
    localparam int LIM_W   = 29;
    localparam int LIMX_W  = LIM_W + 1;

    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    typedef logic [MODE_W-1:0]    t_mode;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_mode MODE_MEAN_GAIN = 2'd0;
    localparam t_mode MODE_SIGMA     = 2'd1;
    localparam t_mode MODE_MIN_MAX   = 2'd2;

    localparam t_cfg_idx CFG_SCALE_MODE   = 2'd0;
    localparam t_cfg_idx CFG_SIGMA_FACTOR = 2'd1;
    localparam t_cfg_idx CFG_MEAN_FACTOR  = 2'd2;

    localparam t_mode             RST_SCALE_MODE   = MODE_MEAN_GAIN;
    localparam logic [FACT_W-1:0] RST_SIGMA_FACTOR = 12'd384;
    localparam logic [FACT_W-1:0] RST_MEAN_FACTOR  = 12'd512;

    localparam logic [LIMX_W-1:0] ONE_Q8 = LIMX_W'(256);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_MUL_N,
        S_MUL_S,
        S_DIFF,
        S_ROOT,
        S_DIV_SIG,
        S_DIV_MEAN,
        S_SCALE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [PIX_W-1:0] px_min;
        logic [PIX_W-1:0] px_max;
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sumsq;
        logic [CNT_W-1:0] count;
    } t_stats;

    typedef struct packed {
        logic busy;
        logic done;
    } t_seq_status;

    typedef struct packed {
        logic [STAT_W-1:0]  mean;
        logic [STAT_W-1:0]  sigma;
        logic [SPROD_W-1:0] scaled;
    } t_calc;

endpackage

`default_nettype wire

// ----- rtl/core/fsac_accum.sv -----
`default_nettype none

module fsac_accum (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_update,
    input  logic [fsac_pkg::PIX_W-1:0]  i_pixel,
    input  logic                        i_clear,
    output fsac_pkg::t_stats            o_stats
);
    import fsac_pkg::*;

    logic [PIX_W-1:0]   r_min, n_min;
    logic [PIX_W-1:0]   r_max, n_max;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [SQ_W-1:0]    r_sumsq, n_sumsq;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [2*PIX_W-1:0] w_square;
    logic               w_room;
    logic               w_first;

    assign w_square = {{PIX_W{1'b0}}, i_pixel} * {{PIX_W{1'b0}}, i_pixel};
    assign w_room   = (r_count < CNT_W'(MAX_PIXELS));
    assign w_first  = (r_count == '0);

    always_comb begin
        n_min   = r_min;
        n_max   = r_max;
        n_sum   = r_sum;
        n_sumsq = r_sumsq;
        n_count = r_count;
        if (i_clear) begin
            n_min   = '0;
            n_max   = '0;
            n_sum   = '0;
            n_sumsq = '0;
            n_count = '0;
        end else if (i_update && w_room) begin
            // Pixels past the frame limit are dropped; the count saturates.
            n_min   = (w_first || i_pixel < r_min) ? i_pixel : r_min;
            n_max   = (w_first || i_pixel > r_max) ? i_pixel : r_max;
            n_sum   = r_sum + SUM_W'(i_pixel);
            n_sumsq = r_sumsq + SQ_W'(w_square);
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min   <= '0;
            r_max   <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
            r_count <= '0;
        end else begin
            r_min   <= n_min;
            r_max   <= n_max;
            r_sum   <= n_sum;
            r_sumsq <= n_sumsq;
            r_count <= n_count;
        end
    end

    assign o_stats = '{px_min: r_min, px_max: r_max, sum: r_sum,
                       sumsq: r_sumsq, count: r_count};

endmodule

`default_nettype wire

// ----- rtl/core/fsac_alu.sv -----
`default_nettype none

module fsac_alu (
    input  logic [fsac_pkg::ALU_W-1:0] i_a,
    input  logic [fsac_pkg::ALU_W-1:0] i_b,
    input  logic                       i_sub,
    output logic [fsac_pkg::ALU_W-1:0] o_res,
    output logic                       o_carry
);
    import fsac_pkg::*;

    logic [ALU_W-1:0] w_b;
    logic [ALU_W:0]   w_full;

    // Carry out of a subtraction is set when a >= b.
    assign w_b     = i_sub ? ~i_b : i_b;
    assign w_full  = {1'b0, i_a} + {1'b0, w_b} + {{ALU_W{1'b0}}, i_sub};
    assign o_res   = w_full[ALU_W-1:0];
    assign o_carry = w_full[ALU_W];

endmodule

`default_nettype wire

// ----- rtl/core/fsac_seq.sv -----
`default_nettype none

module fsac_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_load,
    input  fsac_pkg::t_stats              i_stats,
    input  fsac_pkg::t_mode               i_mode,
    input  logic [fsac_pkg::FACT_W-1:0]   i_sigma_factor,
    input  logic [fsac_pkg::FACT_W-1:0]   i_mean_factor,
    output fsac_pkg::t_seq_status         o_status,
    output fsac_pkg::t_calc               o_calc
);
    import fsac_pkg::*;

    t_state              r_state, n_state;
    logic [ALU_W-1:0]    r_acc, n_acc;
    logic [ALU_W-1:0]    r_opa, n_opa;
    logic [X_W-1:0]      r_opb, n_opb;
    logic [PROD_W-1:0]   r_hold, n_hold;
    logic [STEP_W-1:0]   r_cnt, n_cnt;
    logic [STAT_W-1:0]   r_mean, n_mean;
    logic [STAT_W-1:0]   r_sigma, n_sigma;
    logic [SPROD_W-1:0]  r_scaled, n_scaled;

    logic [ALU_W-1:0]    w_a, w_b, w_res;
    logic                w_sub, w_carry;
    logic [ALU_W-1:0]    w_rem_root, w_trial, w_rem_div, w_n_ext;
    logic                w_last;
    logic [STAT_W-1:0]   w_scale_sel;
    logic [FACT_W-1:0]   w_scale_fact;
    logic [SPROD_W-1:0]  w_scale_prod;

    assign w_last     = (r_cnt == STEP_W'(1));
    assign w_rem_root = {r_acc[ALU_W-3:0], r_opb[X_W-1 -: 2]};
    assign w_trial    = {r_opa[ALU_W-3:0], 2'b01};
    assign w_rem_div  = {r_acc[ALU_W-2:0], r_opb[DV_W-1]};
    assign w_n_ext    = ALU_W'(i_stats.count);

    assign w_scale_sel  = (i_mode == MODE_SIGMA) ? r_sigma : r_mean;
    assign w_scale_fact = (i_mode == MODE_SIGMA) ? i_sigma_factor : i_mean_factor;
    assign w_scale_prod = SPROD_W'(w_scale_sel) * SPROD_W'(w_scale_fact);

    always_comb begin
        unique case (r_state)
            S_MUL_N, S_MUL_S: begin
                w_a   = r_acc;
                w_b   = r_opa;
                w_sub = 1'b0;
            end
            S_DIFF: begin
                w_a   = ALU_W'(r_hold);
                w_b   = r_acc;
                w_sub = 1'b1;
            end
            S_ROOT: begin
                w_a   = w_rem_root;
                w_b   = w_trial;
                w_sub = 1'b1;
            end
            S_DIV_SIG, S_DIV_MEAN: begin
                w_a   = w_rem_div;
                w_b   = w_n_ext;
                w_sub = 1'b1;
            end
            default: begin
                w_a   = r_acc;
                w_b   = r_opa;
                w_sub = 1'b0;
            end
        endcase
    end

    fsac_alu u_alu (
        .i_a     (w_a),
        .i_b     (w_b),
        .i_sub   (w_sub),
        .o_res   (w_res),
        .o_carry (w_carry)
    );

    always_comb begin
        n_state  = r_state;
        n_acc    = r_acc;
        n_opa    = r_opa;
        n_opb    = r_opb;
        n_hold   = r_hold;
        n_cnt    = r_cnt;
        n_mean   = r_mean;
        n_sigma  = r_sigma;
        n_scaled = r_scaled;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_SETUP;
            end
            S_SETUP: begin
                n_acc   = '0;
                n_opa   = ALU_W'(i_stats.sumsq);
                n_opb   = X_W'(i_stats.count);
                n_cnt   = STEP_W'(CNT_W);
                n_state = S_MUL_N;
            end
            S_MUL_N: begin
                if (r_opb[0]) n_acc = w_res;
                n_opa = r_opa << 1;
                n_opb = r_opb >> 1;
                n_cnt = r_cnt - STEP_W'(1);
                if (w_last) begin
                    n_hold  = n_acc[PROD_W-1:0];
                    n_acc   = '0;
                    n_opa   = ALU_W'(i_stats.sum);
                    n_opb   = X_W'(i_stats.sum);
                    n_cnt   = STEP_W'(SUM_W);
                    n_state = S_MUL_S;
                end
            end
            S_MUL_S: begin
                if (r_opb[0]) n_acc = w_res;
                n_opa = r_opa << 1;
                n_opb = r_opb >> 1;
                n_cnt = r_cnt - STEP_W'(1);
                if (w_last) n_state = S_DIFF;
            end
            S_DIFF: begin
                // n * sum_sq - sum^2 is n^2 times the variance; scale by 2^16 for Q.8 sigma.
                n_opb   = {w_res[PROD_W-1:0], {VAR_FRAC_W{1'b0}}};
                n_acc   = '0;
                n_opa   = '0;
                n_cnt   = STEP_W'(RT_W);
                n_state = S_ROOT;
            end
            S_ROOT: begin
                n_acc = w_carry ? w_res : w_rem_root;
                n_opa = {r_opa[ALU_W-2:0], w_carry};
                n_opb = r_opb << 2;
                n_cnt = r_cnt - STEP_W'(1);
                if (w_last) begin
                    // floor(root / n) equals the floor of 2^8 times the square root of the variance (Q.8 sigma).
                    n_opb   = X_W'(n_opa[RT_W-1:0]);
                    n_acc   = '0;
                    n_opa   = '0;
                    n_cnt   = STEP_W'(DV_W);
                    n_state = S_DIV_SIG;
                end
            end
            S_DIV_SIG: begin
                n_acc = w_carry ? w_res : w_rem_div;
                n_opa = {r_opa[ALU_W-2:0], w_carry};
                n_opb = r_opb << 1;
                n_cnt = r_cnt - STEP_W'(1);
                if (w_last) begin
                    n_sigma = n_opa[STAT_W-1:0];
                    n_opb   = X_W'({i_stats.sum, {MEAN_FRAC_W{1'b0}}});
                    n_acc   = '0;
                    n_opa   = '0;
                    n_cnt   = STEP_W'(DV_W);
                    n_state = S_DIV_MEAN;
                end
            end
            S_DIV_MEAN: begin
                n_acc = w_carry ? w_res : w_rem_div;
                n_opa = {r_opa[ALU_W-2:0], w_carry};
                n_opb = r_opb << 1;
                n_cnt = r_cnt - STEP_W'(1);
                if (w_last) begin
                    n_mean  = n_opa[STAT_W-1:0];
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                n_scaled = w_scale_prod;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_opa    <= n_opa;
        r_opb    <= n_opb;
        r_hold   <= n_hold;
        r_mean   <= n_mean;
        r_sigma  <= n_sigma;
        r_scaled <= n_scaled;
    end

    assign o_status = '{busy: (r_state != S_IDLE), done: (r_state == S_DONE)};
    assign o_calc   = '{mean: r_mean, sigma: r_sigma, scaled: r_scaled};

endmodule

`default_nettype wire

// ----- rtl/core/fsac_limits.sv -----
`default_nettype none

module fsac_limits (
    input  fsac_pkg::t_mode                    i_mode,
    input  fsac_pkg::t_calc                    i_calc,
    input  logic [fsac_pkg::PIX_W-1:0]         i_min,
    input  logic [fsac_pkg::PIX_W-1:0]         i_max,
    output logic signed [fsac_pkg::LIM_W-1:0]  o_low,
    output logic signed [fsac_pkg::LIM_W-1:0]  o_high
);
    import fsac_pkg::*;

    logic [LIMX_W-1:0] w_k;
    logic [LIMX_W-1:0] w_mean;
    logic [LIMX_W-1:0] w_low;
    logic [LIMX_W-1:0] w_high;
    logic [LIMX_W-1:0] w_high_adj;

    assign w_k    = LIMX_W'(i_calc.scaled[SPROD_W-1:8]);
    assign w_mean = LIMX_W'(i_calc.mean);

    // One extra bit keeps mean + k from wrapping before the equality check.
    always_comb begin
        unique case (i_mode)
            MODE_MEAN_GAIN: begin
                w_low  = '0;
                w_high = w_k;
            end
            MODE_SIGMA: begin
                w_low  = w_mean - w_k;
                w_high = w_mean + w_k;
            end
            default: begin
                w_low  = LIMX_W'({i_min, 8'd0});
                w_high = LIMX_W'({i_max, 8'd0});
            end
        endcase
    end

    assign w_high_adj = (w_high == w_low) ? w_high + ONE_Q8 : w_high;
    assign o_low      = $signed(w_low[LIM_W-1:0]);
    assign o_high     = $signed(w_high_adj[LIM_W-1:0]);

endmodule

`default_nettype wire

// ----- rtl/core/frame_stats_auto_contrast.sv -----
// Channel  Dir  Handshake                    Payload
// pixel    in   i_in_valid / o_in_stall      i_pixel_value, i_frame_end
// result   out  o_out_valid / i_out_stall    o_frame_min, o_frame_max, o_frame_mean,
//                                            o_frame_sigma, o_low_limit, o_high_limit
// config   in   i_cfg_we                     i_cfg_index, i_cfg_data
//
// Pixels transfer one per cycle while the sequencer is idle.
// A frame-end transfer starts the sequencer, which stalls the pixel input until its result
// is loaded into the output register: one step of the shared add/subtract unit per cycle
// for n*sum_sq, sum^2, square root and two divides.
// A result waiting in the output register does not block pixels; after the next frame end the sequencer waits for it.
// Reset is synchronous, active low, and restores the configuration reset values.
`default_nettype none

module frame_stats_auto_contrast (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [fsac_pkg::PIX_W-1:0]             i_pixel_value,
    input  logic                                   i_frame_end,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [fsac_pkg::PIX_W-1:0]             o_frame_min,
    output logic [fsac_pkg::PIX_W-1:0]             o_frame_max,
    output logic [fsac_pkg::STAT_W-1:0]            o_frame_mean,
    output logic [fsac_pkg::STAT_W-1:0]            o_frame_sigma,
    output logic signed [fsac_pkg::LIM_W-1:0]      o_low_limit,
    output logic signed [fsac_pkg::LIM_W-1:0]      o_high_limit,
    input  logic                                   i_cfg_we,
    input  logic [fsac_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [fsac_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import fsac_pkg::*;

    t_mode               r_scale_mode;
    logic [FACT_W-1:0]   r_sigma_factor;
    logic [FACT_W-1:0]   r_mean_factor;

    logic                r_out_valid;
    logic [PIX_W-1:0]    r_frame_min;
    logic [PIX_W-1:0]    r_frame_max;
    logic [STAT_W-1:0]   r_frame_mean;
    logic [STAT_W-1:0]   r_frame_sigma;
    logic signed [LIM_W-1:0] r_low_limit;
    logic signed [LIM_W-1:0] r_high_limit;

    t_stats              w_stats;
    t_seq_status         w_status;
    t_calc               w_calc;
    logic                w_in_xfer;
    logic                w_start;
    logic                w_load;
    logic signed [LIM_W-1:0] w_low;
    logic signed [LIM_W-1:0] w_high;

    assign o_in_stall = w_status.busy;
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_start    = w_in_xfer && i_frame_end;
    assign w_load     = w_status.done && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_mode   <= RST_SCALE_MODE;
            r_sigma_factor <= RST_SIGMA_FACTOR;
            r_mean_factor  <= RST_MEAN_FACTOR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SCALE_MODE:   r_scale_mode   <= i_cfg_data[MODE_W-1:0];
                CFG_SIGMA_FACTOR: r_sigma_factor <= i_cfg_data[FACT_W-1:0];
                CFG_MEAN_FACTOR:  r_mean_factor  <= i_cfg_data[FACT_W-1:0];
                default: ;
            endcase
        end
    end

    fsac_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (w_in_xfer),
        .i_pixel  (i_pixel_value),
        .i_clear  (w_load),
        .o_stats  (w_stats)
    );

    fsac_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (w_start),
        .i_load         (w_load),
        .i_stats        (w_stats),
        .i_mode         (r_scale_mode),
        .i_sigma_factor (r_sigma_factor),
        .i_mean_factor  (r_mean_factor),
        .o_status       (w_status),
        .o_calc         (w_calc)
    );

    fsac_limits u_limits (
        .i_mode (r_scale_mode),
        .i_calc (w_calc),
        .i_min  (w_stats.px_min),
        .i_max  (w_stats.px_max),
        .o_low  (w_low),
        .o_high (w_high)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_frame_min   <= w_stats.px_min;
            r_frame_max   <= w_stats.px_max;
            r_frame_mean  <= w_calc.mean;
            r_frame_sigma <= w_calc.sigma;
            r_low_limit   <= w_low;
            r_high_limit  <= w_high;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_frame_min   = r_frame_min;
    assign o_frame_max   = r_frame_max;
    assign o_frame_mean  = r_frame_mean;
    assign o_frame_sigma = r_frame_sigma;
    assign o_low_limit   = r_low_limit;
    assign o_high_limit  = r_high_limit;

endmodule

`default_nettype wire

// ----- rtl/core/fsac_checker.sv -----
`default_nettype none

module fsac_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  logic                                   o_in_stall,
    input  logic                                   i_frame_end,
    input  logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    input  logic [fsac_pkg::PIX_W-1:0]             o_frame_min,
    input  logic [fsac_pkg::PIX_W-1:0]             o_frame_max,
    input  logic [fsac_pkg::STAT_W-1:0]            o_frame_mean,
    input  logic signed [fsac_pkg::LIM_W-1:0]      o_low_limit,
    input  logic signed [fsac_pkg::LIM_W-1:0]      o_high_limit
);

    // A frame end must hand the block over to the sequencer.
    a_frame_end_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_frame_end) |=> o_in_stall)
        else $error("pixel input not stalled after a frame-end transfer");

    // Results only come out of a busy sequencer.
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared while the sequencer was idle");

    a_limits_differ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_high_limit != o_low_limit))
        else $error("display limits are equal");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_frame_min <= o_frame_max))
        else $error("frame minimum above frame maximum");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_frame_mean) && $stable(o_high_limit)))
        else $error("stalled result changed");

endmodule

bind frame_stats_auto_contrast fsac_checker u_fsac_checker (.*);

`default_nettype wire
